/* sv/tfcm_pkg.sv */
// Package for the transfer-function colour map pipeline.
// Holds shared codes, reset values, inter-stage structs and the channel blend.
// No dependencies.
package tfcm_pkg;

  // Item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_MAP  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_VALUE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_SIZE = 2'd2;

  // Register widths and reset values
  localparam int unsigned SIZE_W = 9;
  localparam logic signed [31:0] MIN_VALUE_RST  = 32'sd0;
  localparam logic [31:0]        SCALE_RST      = 32'd65536;
  localparam logic [SIZE_W-1:0]  TABLE_SIZE_RST = 9'd0;

  // Default table depth
  localparam int unsigned DEFAULT_TABLE_DEPTH = 256;

  // Transaction leaving the multiply stage
  typedef struct packed {
    logic        is_map;
    logic        neg;
    logic [63:0] pos;
    logic [7:0]  idx;
    logic [31:0] rgba;
  } mul_t;

  // Transaction leaving the table lookup stage
  typedef struct packed {
    logic        zero;
    logic [7:0]  frac;
    logic [31:0] lo;
    logic [31:0] hi;
  } lookup_t;

  // Blend one 8-bit channel with rounding: (lo*(256-f) + hi*f + 128) >> 8
  function automatic logic [7:0] blend_channel(input logic [7:0] lo, input logic [7:0] hi,
                                               input logic [7:0] frac);
    logic [16:0] acc;
    acc = 17'(lo) * (17'd256 - 17'(frac)) + 17'(hi) * 17'(frac) + 17'd128;
    return acc[15:8];
  endfunction

endpackage

/* sv/tfcm_front.sv */
// Front of the colour map pipeline: offset subtraction and Q16.16 scaling.
// Two register stages; depends on tfcm_pkg.
module tfcm_front import tfcm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [7:0]         in_entry_index,
  input  logic [31:0]        in_entry_rgba,
  input  logic signed [31:0] in_sample,
  input  logic signed [31:0] min_value,
  input  logic [31:0]        scale,
  output logic               mul_valid,
  output mul_t               mul_data,
  input  logic               mul_ready
);

  logic               v1_r, v2_r;
  logic               en1, en2;
  logic               mode1_r;
  logic [7:0]         idx1_r;
  logic [31:0]        rgba1_r;
  logic               neg1_r;
  logic [31:0]        diff1_r;
  logic signed [32:0] diff_nxt;
  logic [63:0]        prod;
  mul_t               mul_r, mul_nxt;

  // Advance a stage when it is empty or its successor takes the transaction
  assign en2      = !v2_r || mul_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Offset the sample; the sign of the 33-bit difference flags below-minimum
  assign diff_nxt = 33'(in_sample) - 33'(min_value);

  // Scale the non-negative difference into table position
  assign prod = 64'(diff1_r) * 64'(scale);

  always_comb begin
    mul_nxt.is_map = (mode1_r == MODE_MAP);
    mul_nxt.neg    = neg1_r;
    mul_nxt.pos    = prod;
    mul_nxt.idx    = idx1_r;
    mul_nxt.rgba   = rgba1_r;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en1) begin
      mode1_r <= in_mode;
      idx1_r  <= in_entry_index;
      rgba1_r <= in_entry_rgba;
      neg1_r  <= diff_nxt[32];
      diff1_r <= diff_nxt[31:0];
    end
    if (en2) mul_r <= mul_nxt;
  end

  assign mul_valid = v2_r;
  assign mul_data  = mul_r;

endmodule

/* sv/tfcm_lookup.sv */
// Table stage of the colour map: entry writes, clamping and dual-port table read.
// One register stage around the colour memory; depends on tfcm_pkg.
module tfcm_lookup import tfcm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              mul_valid,
  input  mul_t              mul_data,
  output logic              mul_ready,
  input  logic [SIZE_W-1:0] table_size,
  output logic              lk_valid,
  output lookup_t           lk_data,
  input  logic              lk_ready
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned SW = AW + 1;

  logic [31:0]   color_mem [TABLE_DEPTH];
  logic          v3_r;
  logic          en3;
  logic [SW-1:0] size_c;
  logic [SW-1:0] size_m1;
  logic [AW-1:0] last_idx;
  logic          empty;
  logic [47:0]   base;
  logic          clamp;
  logic [AW-1:0] addr_a, addr_b;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          zero3_r;
  logic [7:0]    frac3_r;
  logic [31:0]   rd_a_r, rd_b_r;

  assign en3       = !v3_r || lk_ready;
  assign mul_ready = en3;

  // Limit the table size to the depth and find the last entry in use
  always_comb begin
    if (32'(table_size) >= 32'(TABLE_DEPTH)) size_c = SW'(TABLE_DEPTH);
    else                                     size_c = SW'(table_size);
  end
  assign empty    = (size_c == '0);
  assign size_m1  = size_c - SW'(1);
  assign last_idx = size_m1[AW-1:0];

  // Clamp positions at or past the last entry onto that entry; both reads
  // then address the last entry so nothing beyond it is touched
  assign base   = mul_data.pos[63:16];
  assign clamp  = (base >= 48'(last_idx));
  assign addr_a = clamp ? last_idx : base[AW-1:0];
  assign addr_b = clamp ? last_idx : addr_a + AW'(1);

  // Drop writes beyond the table
  assign wr_en   = en3 && mul_valid && !mul_data.is_map
                   && (32'(mul_data.idx) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(mul_data.idx);

  // Colour memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) color_mem[wr_addr] <= mul_data.rgba;
    if (en3) begin
      rd_a_r <= color_mem[addr_a];
      rd_b_r <= color_mem[addr_b];
    end
  end

  // Side information travelling with the read; a clamped read blends nothing
  always_ff @(posedge clk) begin
    if (en3) begin
      zero3_r <= mul_data.neg || empty;
      frac3_r <= clamp ? 8'd0 : mul_data.pos[15:8];
    end
  end

  // Load transactions end here
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en3) v3_r <= mul_valid && mul_data.is_map;
  end

  assign lk_valid = v3_r;
  assign lk_data  = '{zero: zero3_r, frac: frac3_r, lo: rd_a_r, hi: rd_b_r};

`ifndef SYNTH
  // A load transaction never occupies the lookup stage
  a_load_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (en3 && mul_valid && !mul_data.is_map) |=> !v3_r)
    else $error("load transaction reached the blend side");

  // A clamped read carries no blend fraction
  a_clamp_frac: assert property (@(posedge clk) disable iff (!rst_n)
    (en3 && mul_valid && mul_data.is_map && clamp) |=> (frac3_r == 8'd0))
    else $error("clamped position kept a fraction");
`endif

endmodule

/* sv/tfcm_blend.sv */
// Output stage of the colour map: per-channel linear blend and result register.
// Depends on tfcm_pkg for the blend function and lookup struct.
module tfcm_blend import tfcm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       lk_valid,
  input  lookup_t    lk_data,
  output logic       lk_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);

  logic       v4_r;
  logic       en4;
  logic [7:0] red_r, green_r, blue_r, alpha_r;
  logic [7:0] red_nxt, green_nxt, blue_nxt, alpha_nxt;

  assign en4      = !v4_r || out_ready;
  assign lk_ready = en4;

  // Blend each channel; a below-minimum sample or empty table gives zero colour
  always_comb begin
    if (lk_data.zero) begin
      red_nxt   = 8'd0;
      green_nxt = 8'd0;
      blue_nxt  = 8'd0;
      alpha_nxt = 8'd0;
    end else begin
      red_nxt   = blend_channel(lk_data.lo[31:24], lk_data.hi[31:24], lk_data.frac);
      green_nxt = blend_channel(lk_data.lo[23:16], lk_data.hi[23:16], lk_data.frac);
      blue_nxt  = blend_channel(lk_data.lo[15:8],  lk_data.hi[15:8],  lk_data.frac);
      alpha_nxt = blend_channel(lk_data.lo[7:0],   lk_data.hi[7:0],   lk_data.frac);
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en4) v4_r <= lk_valid;
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (en4) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;
  assign out_alpha = alpha_r;

`ifndef SYNTH
  // Zero-colour transactions leave as black
  a_zero_black: assert property (@(posedge clk) disable iff (!rst_n)
    (en4 && lk_valid && lk_data.zero) |=>
      (red_r == 8'd0 && green_r == 8'd0 && blue_r == 8'd0 && alpha_r == 8'd0))
    else $error("zero-colour transaction produced colour");
`endif

endmodule

/* sv/transfer_function_color_map.sv */
// Transfer-function colour map: scalar samples to interpolated RGBA8 colours.
// Top level; instantiates tfcm_front, tfcm_lookup and tfcm_blend, uses tfcm_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries load and map transactions. A load
//   (in_mode 0) writes in_entry_rgba into table entry in_entry_index and yields
//   no result. A map (in_mode 1) subtracts min_value from in_sample, scales by
//   the Q16.16 factor and blends two neighbouring entries by 8 fraction bits.
//   Output channel (out_valid/out_ready) carries one colour per map transaction.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0 min_value, 1 scale, 2 table_size); the user must write only while no
//   transaction is in flight, as the block itself does not enforce this.
//   Results leave the last of four register stages (offset, multiply, table
//   read, blend). One transaction per cycle is taken without receiver stalls,
//   set by the four-stage pipeline and the dual-read colour memory.
//   Reset clears the stage valid bits and the registers to min_value 0, scale
//   1.0 and an empty table; table contents stay undefined until written.
//   When the receiver stalls, results hold and empty stages still fill;
//   in_ready falls only once all four stages are occupied.
module transfer_function_color_map import tfcm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_mode,
  input  logic [7:0]             in_entry_index,
  input  logic [31:0]            in_entry_rgba,
  input  logic signed [31:0]     in_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue,
  output logic [7:0]             out_alpha,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_wdata
);

  logic signed [31:0] min_value_r;
  logic [31:0]        scale_r;
  logic [SIZE_W-1:0]  table_size_r;
  logic               mul_valid, mul_ready;
  mul_t               mul_data;
  logic               lk_valid, lk_ready;
  lookup_t            lk_data;

  // Configuration registers; writes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_value_r  <= MIN_VALUE_RST;
      scale_r      <= SCALE_RST;
      table_size_r <= TABLE_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_VALUE:  min_value_r  <= cfg_wdata;
        CFG_SCALE:      scale_r      <= cfg_wdata;
        CFG_TABLE_SIZE: table_size_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  tfcm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_entry_rgba  (in_entry_rgba),
    .in_sample      (in_sample),
    .min_value      (min_value_r),
    .scale          (scale_r),
    .mul_valid      (mul_valid),
    .mul_data       (mul_data),
    .mul_ready      (mul_ready)
  );

  tfcm_lookup #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_lookup (
    .clk        (clk),
    .rst_n      (rst_n),
    .mul_valid  (mul_valid),
    .mul_data   (mul_data),
    .mul_ready  (mul_ready),
    .table_size (table_size_r),
    .lk_valid   (lk_valid),
    .lk_data    (lk_data),
    .lk_ready   (lk_ready)
  );

  tfcm_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .lk_valid  (lk_valid),
    .lk_data   (lk_data),
    .lk_ready  (lk_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

`ifndef SYNTH
  // Back-pressure reaches the input only through a stalled, full pipeline
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without an output stall");
`endif

endmodule
